/* rtl/ssc_pkg.sv */
// Shared types and constants for the source style checker.
package ssc_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;

    localparam int         MAX_LEN_BITS  = 10;
    localparam logic [9:0] MAX_LEN_RESET = 10'd80;
    localparam int         ERR_BITS      = 16;
    localparam int         OUT_LINE_BITS = 16;
    localparam int         OUT_UNIT_BITS = 10;

    // register index decoded from paddr[2]
    localparam logic       REG_MAX_LEN = 1'b0;

    localparam int         Q_DEPTH = 2;

    // byte class handed from the front to the back
    typedef struct packed {
        logic newline;
        logic space;
        logic tab;
    } t_cls;

    typedef enum logic {
        BS_RUN,
        BS_MOD
    } t_bstate;

endpackage

/* rtl/ssc_front.sv */
// Front end: accepts text bytes, classifies them and queues the class.
module ssc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_char_code,
    output logic          o_q_valid,
    output ssc_pkg::t_cls o_q_item,
    input  logic          i_pop
);

    ssc_pkg::t_cls r_mem [ssc_pkg::Q_DEPTH];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    ssc_pkg::t_cls cls;
    logic          full;
    logic          push;

    always_comb begin
        cls.newline = (i_char_code == ssc_pkg::CH_NEWLINE);
        cls.space   = (i_char_code == ssc_pkg::CH_SPACE);
        cls.tab     = (i_char_code == ssc_pkg::CH_TAB);
    end

    assign full      = (r_cnt == 2'(ssc_pkg::Q_DEPTH));
    assign o_stall   = full;
    assign push      = i_valid && !full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/ssc_mod.sv */
// Bit-serial remainder unit: tells whether dividend mod divisor is nonzero.
module ssc_mod #(
    parameter int COUNT_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic                  o_rem_nonzero
);

    localparam int CW = $clog2(COUNT_BITS + 1);

    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvd;
    logic [COUNT_BITS-1:0] r_dvs;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic [COUNT_BITS-1:0] n_rem;

    // shift in one dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_dvd[COUNT_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[COUNT_BITS-1:0];
        end else begin
            n_rem = trial[COUNT_BITS-1:0];
        end
    end

    assign o_done        = !r_busy;
    assign o_rem_nonzero = (r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[COUNT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(COUNT_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* rtl/ssc_back.sv */
// Back end: line state, layout checks, error total and the result register.
module ssc_back #(
    parameter int LINE_BITS  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [9:0]    i_max_len,
    input  logic          i_q_valid,
    input  ssc_pkg::t_cls i_q_item,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_line_number,
    output logic          o_length_error,
    output logic          o_indent_error,
    output logic          o_tab_error,
    output logic [9:0]    o_indent_width,
    output logic [15:0]   o_error_total
);

    localparam int CMP_W = (COUNT_BITS > ssc_pkg::MAX_LEN_BITS) ?
                           COUNT_BITS : ssc_pkg::MAX_LEN_BITS;
    localparam int EW    = ssc_pkg::ERR_BITS;

    ssc_pkg::t_bstate      r_state;
    ssc_pkg::t_bstate      n_state;
    ssc_pkg::t_cls         r_item;
    ssc_pkg::t_cls         cur;

    logic [LINE_BITS-1:0]  r_line;
    logic [COUNT_BITS-1:0] r_char;
    logic [COUNT_BITS-1:0] r_space;
    logic [COUNT_BITS-1:0] r_unit;
    logic                  r_in_indent;
    logic [EW-1:0]         r_err;

    logic [LINE_BITS-1:0]  n_line;
    logic [COUNT_BITS-1:0] n_char;
    logic [COUNT_BITS-1:0] n_space;
    logic [COUNT_BITS-1:0] n_unit;
    logic                  n_in_indent;
    logic [EW-1:0]         n_err;

    logic                  r_out_valid;
    logic [15:0]           r_out_line;
    logic                  r_out_len;
    logic                  r_out_ind;
    logic                  r_out_tab;
    logic [9:0]            r_out_unit;
    logic [15:0]           r_out_err;

    logic                  out_free;
    logic                  needs_mod;
    logic                  mod_start;
    logic                  mod_done;
    logic                  mod_nonzero;
    logic                  commit;
    logic                  len_err;
    logic                  ind_err;
    logic                  tab_err;
    logic [1:0]            err_inc;
    logic [EW:0]           err_sum;
    logic [15:0]           line_here;
    logic [COUNT_BITS-1:0] char_inc;
    logic [COUNT_BITS-1:0] space_inc;

    ssc_mod #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mod (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (mod_start),
        .i_dividend    (r_space),
        .i_divisor     (r_unit),
        .o_done        (mod_done),
        .o_rem_nonzero (mod_nonzero)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign cur       = (r_state == ssc_pkg::BS_MOD) ? r_item : i_q_item;
    assign needs_mod = cur.newline && (r_unit != '0) && r_in_indent;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssc_pkg::BS_RUN: begin
                if (i_q_valid && needs_mod) begin
                    n_state = ssc_pkg::BS_MOD;
                end
            end
            ssc_pkg::BS_MOD: begin
                if (mod_done && out_free) begin
                    n_state = ssc_pkg::BS_RUN;
                end
            end
            default: n_state = ssc_pkg::BS_RUN;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        mod_start = 1'b0;
        commit    = 1'b0;
        case (r_state)
            ssc_pkg::BS_RUN: begin
                if (i_q_valid && needs_mod) begin
                    o_pop     = 1'b1;
                    mod_start = 1'b1;
                end else if (i_q_valid && out_free) begin
                    o_pop  = 1'b1;
                    commit = 1'b1;
                end
            end
            ssc_pkg::BS_MOD: begin
                commit = mod_done && out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // per-item update of the line state
    always_comb begin
        char_inc    = (r_char == '1) ? r_char : r_char + COUNT_BITS'(1);
        space_inc   = (r_space == '1) ? r_space : r_space + COUNT_BITS'(1);
        len_err     = 1'b0;
        ind_err     = 1'b0;
        tab_err     = 1'b0;
        n_line      = r_line;
        n_char      = r_char;
        n_space     = r_space;
        n_unit      = r_unit;
        n_in_indent = r_in_indent;
        if (cur.newline) begin
            len_err = CMP_W'(r_char) > CMP_W'(i_max_len);
            if (r_unit == '0) begin
                if (r_space != '0) begin
                    n_unit = r_space;
                end
            end else begin
                ind_err = r_in_indent && mod_nonzero;
            end
            if (r_line != '1) begin
                n_line = r_line + LINE_BITS'(1);
            end
            n_char      = '0;
            n_space     = '0;
            n_in_indent = 1'b1;
        end else begin
            n_char = char_inc;
            if (cur.space) begin
                if (r_in_indent) begin
                    n_space = space_inc;
                end
            end else if (cur.tab && r_in_indent) begin
                tab_err = 1'b1;
            end else begin
                n_in_indent = 1'b0;
            end
        end
        err_inc = {1'b0, len_err} + {1'b0, ind_err} + {1'b0, tab_err};
        err_sum = {1'b0, r_err} + (EW + 1)'(err_inc);
        n_err   = err_sum[EW] ? '1 : err_sum[EW-1:0];
    end

    // line shown for the byte: the counter before it advances, clipped
    always_comb begin
        if (r_line > LINE_BITS'(32'hFFFF)) begin
            line_here = 16'hFFFF;
        end else begin
            line_here = 16'(r_line);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssc_pkg::BS_RUN;
            r_line      <= LINE_BITS'(1);
            r_char      <= '0;
            r_space     <= '0;
            r_unit      <= '0;
            r_in_indent <= 1'b1;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_line      <= n_line;
                r_char      <= n_char;
                r_space     <= n_space;
                r_unit      <= n_unit;
                r_in_indent <= n_in_indent;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_start) begin
            r_item <= i_q_item;
        end
        if (commit) begin
            r_out_line <= line_here;
            r_out_len  <= len_err;
            r_out_ind  <= ind_err;
            r_out_tab  <= tab_err;
            r_out_unit <= 10'(n_unit);
            r_out_err  <= 16'(n_err);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_line_number  = r_out_line;
    assign o_length_error = r_out_len;
    assign o_indent_error = r_out_ind;
    assign o_tab_error    = r_out_tab;
    assign o_indent_width = r_out_unit;
    assign o_error_total  = r_out_err;

endmodule

/* rtl/source_style_checker.sv */
// Top level of the source style checker: config register, front, back.
// An ordinary byte passes through the queue and the result register; a newline
// that needs the indent remainder also waits on the bit-serial remainder unit.
// Throughput: one byte per cycle while i_stall does not hold the result; a remainder
// newline holds the back end while the remainder unit runs, and the 2-entry queue
// keeps taking bytes meanwhile until it is full. Synchronous active-low reset clears
// all line state (line 1, indent width unknown) and sets the line limit to 80.
module source_style_checker #(
    parameter int LINE_BITS  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_line_number,
    output logic        o_length_error,
    output logic        o_indent_error,
    output logic        o_tab_error,
    output logic [9:0]  o_indent_width,
    output logic [15:0] o_error_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]    r_max_len;
    logic          q_valid;
    ssc_pkg::t_cls q_item;
    logic          pop;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ssc_pkg::MAX_LEN_RESET;
        end else if (cfg_wr && (paddr[2] == ssc_pkg::REG_MAX_LEN)) begin
            r_max_len <= pwdata[9:0];
        end
    end

    always_comb begin
        if (paddr[2] == ssc_pkg::REG_MAX_LEN) begin
            prdata = {22'd0, r_max_len};
        end else begin
            prdata = '0;
        end
    end

    ssc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_pop       (pop)
    );

    ssc_back #(
        .LINE_BITS  (LINE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_len      (r_max_len),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_number  (o_line_number),
        .o_length_error (o_length_error),
        .o_indent_error (o_indent_error),
        .o_tab_error    (o_tab_error),
        .o_indent_width (o_indent_width),
        .o_error_total  (o_error_total)
    );

    // newline checks and the tab check never fire on the same item
    a_err_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_length_error || o_indent_error) |-> !o_tab_error)
        else $error("tab error flagged on a newline item");

    a_ind_needs_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_indent_error |-> o_indent_width != 10'd0)
        else $error("indent error without a known indent width");

    a_err_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_tab_error || o_length_error || o_indent_error)
        |-> o_error_total != 16'd0)
        else $error("flagged item left the error total at zero");

endmodule
